@@ rtl/pfd_pkg.sv @@
// shared types, constants and saturation helpers for the filtered-derivative pid block
package pfd_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned DIV_STEPS = 48;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_BOUND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_BOUND    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ALPHA   = 3'd5;

  localparam logic        KIND_UPDATE = 1'b0;
  localparam logic        KIND_CLEAR  = 1'b1;
  localparam logic [16:0] Q_ONE       = 17'h10000;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] error_in;
    logic signed [31:0] measure_in;
    logic signed [31:0] step_time;
  } item_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               rejected;
  } result_t;

  typedef struct packed {
    logic        start;
    logic [47:0] dividend;
    logic [30:0] divisor;
  } div_req_t;

  function automatic logic signed [65:0] ext66(input logic signed [31:0] x);
    return {{34{x[31]}}, x};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    if (x[65:31] == '0 || x[65:31] == '1) begin
      return x[31:0];
    end
    return x[65] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

  // floor of product / 2^16, saturated
  function automatic logic signed [31:0] qsat(input logic signed [65:0] p);
    return sat32(p >>> 16);
  endfunction

  function automatic logic signed [31:0] clampsym(input logic signed [31:0] x,
                                                  input logic [30:0] bound);
    logic signed [32:0] xb;
    logic signed [32:0] bp;
    logic signed [32:0] bn;
    xb = {x[31], x};
    bp = {2'b00, bound};
    bn = -bp;
    if (xb > bp) begin
      return bp[31:0];
    end
    if (xb < bn) begin
      return bn[31:0];
    end
    return x;
  endfunction

endpackage

@@ rtl/pfd_mul.sv @@
// shared signed 33x33 multiplier with registered product
module pfd_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] prod
);
  import pfd_pkg::*;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

@@ rtl/pfd_div.sv @@
// restoring serial divider, one quotient bit per cycle
module pfd_div (
  input  logic              clk,
  input  logic              rst,
  input  pfd_pkg::div_req_t req,
  output logic              busy,
  output logic [47:0]       quotient
);
  import pfd_pkg::*;

  logic [30:0]          rem;
  logic [30:0]          dvs;
  logic [DIV_CNT_W-1:0] count;
  logic [31:0]          rem_sh;
  logic [31:0]          rem_sub;
  logic                 take;

  assign rem_sh  = {rem, quotient[47]};
  assign take    = rem_sh >= {1'b0, dvs};
  assign rem_sub = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (req.start) begin
      busy     <= 1'b1;
      count    <= '0;
      rem      <= '0;
      dvs      <= req.divisor;
      quotient <= req.dividend;
    end else if (busy) begin
      rem      <= take ? rem_sub[30:0] : rem_sh[30:0];
      quotient <= {quotient[46:0], take};
      count    <= count + 1'b1;
      if (count == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/pid_filtered_derivative_top.sv @@
// top level: pid step with filtered derivative on measurement, sequencer and state
// usage:
//   item channel (item_valid/item_ready, payload item) takes one transaction at a time;
//   kind clear resets integrator, previous measurement, previous derivative and the
//   primed flag and gives no result
//   an update with step_time not positive gives drive 0, rejected 1 via the emit step
//   and leaves the state alone
//   an update with positive step_time raises result_valid once its result is emitted,
//   and the next transaction can be taken in the same cycle that result_valid rises;
//   the serial quotient of the measurement difference by step_time runs beside
//   single passes through the one shared 33x33 multiplier and the saturating adders
//   result channel (result_valid/result_ready, payload result) has its own register,
//   so a new item is taken while a result waits; the block holds its last step
//   until that register is free when the receiver stalls
//   cfg_write with cfg_index and cfg_data sets a gain, bound or alpha; the user
//   writes only while the block is idle, not enforced by the block itself; indices
//   past the list are ignored; rst zeroes control, configuration and controller state
module pid_filtered_derivative_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_ready,
  input  pfd_pkg::item_t                   item,
  output logic                             result_valid,
  input  logic                             result_ready,
  output pfd_pkg::result_t                 result,
  input  logic                             cfg_write,
  input  logic [pfd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                      cfg_data
);
  import pfd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_GI,
    ST_MUL_GP,
    ST_MUL_T1,
    ST_ACC_I,
    ST_CLAMP_I,
    ST_SUM_P,
    ST_WAIT_DIV,
    ST_MUL_ALPHA,
    ST_DERIV,
    ST_MUL_GD,
    ST_SUM_D,
    ST_CLAMP_OUT,
    ST_EMIT
  } state_t;

  state_t state;

  logic signed [31:0] gain_p;
  logic signed [31:0] gain_i;
  logic signed [31:0] gain_d;
  logic [30:0]        integral_bound;
  logic [30:0]        drive_bound;
  logic [16:0]        filter_alpha;

  logic signed [31:0] integral_acc;
  logic signed [31:0] last_measure;
  logic signed [31:0] last_deriv;
  logic               primed;

  logic signed [31:0] err;
  logic signed [31:0] meas;
  logic signed [31:0] dt;
  logic signed [31:0] t1;
  logic signed [31:0] p_term;
  logic signed [31:0] out_acc;
  logic signed [31:0] raw;
  logic               quot_neg;
  logic signed [31:0] fin_drive;
  logic               fin_rej;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] prod;

  div_req_t           div_req;
  logic               div_busy;
  logic [47:0]        quotient;

  logic               accept;
  logic               step_ok;
  logic               out_free;
  logic signed [32:0] diff;
  logic [32:0]        diff_abs;
  logic signed [31:0] raw_sat;
  logic [16:0]        alpha_eff;
  logic signed [32:0] deriv_gap;

  assign item_ready = state == ST_IDLE;
  assign accept     = item_valid && item_ready;
  assign step_ok    = !item.step_time[31] && item.step_time != 32'sd0;
  assign out_free   = !result_valid || result_ready;

  assign diff     = {meas[31], meas} - {last_measure[31], last_measure};
  assign diff_abs = diff[32] ? -diff : diff;

  always_comb begin
    div_req.start    = state == ST_MUL_GI;
    div_req.dividend = {diff_abs[31:0], 16'h0000};
    div_req.divisor  = dt[30:0];
  end

  always_comb begin
    if (!quot_neg) begin
      raw_sat = (quotient[47:31] != '0) ? 32'sh7FFF_FFFF : quotient[31:0];
    end else if (quotient[47:32] != '0 || (quotient[31] && quotient[30:0] != '0)) begin
      raw_sat = 32'sh8000_0000;
    end else begin
      raw_sat = -quotient[31:0];
    end
  end

  assign alpha_eff = (filter_alpha > Q_ONE) ? Q_ONE : filter_alpha;
  assign deriv_gap = {raw[31], raw} - {last_deriv[31], last_deriv};

  always_comb begin
    unique case (state)
      ST_MUL_GP: begin
        mul_a = {gain_p[31], gain_p};
        mul_b = {err[31], err};
      end
      ST_MUL_T1: begin
        mul_a = {t1[31], t1};
        mul_b = {dt[31], dt};
      end
      ST_MUL_ALPHA: begin
        mul_a = {16'h0000, alpha_eff};
        mul_b = deriv_gap;
      end
      ST_MUL_GD: begin
        mul_a = {gain_d[31], gain_d};
        mul_b = {last_deriv[31], last_deriv};
      end
      default: begin
        mul_a = {gain_i[31], gain_i};
        mul_b = {err[31], err};
      end
    endcase
  end

  pfd_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  pfd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .busy     (div_busy),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p         <= '0;
      gain_i         <= '0;
      gain_d         <= '0;
      integral_bound <= '0;
      drive_bound    <= '0;
      filter_alpha   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_GAIN_P:         gain_p         <= cfg_data;
        CFG_GAIN_I:         gain_i         <= cfg_data;
        CFG_GAIN_D:         gain_d         <= cfg_data;
        CFG_INTEGRAL_BOUND: integral_bound <= cfg_data[30:0];
        CFG_DRIVE_BOUND:    drive_bound    <= cfg_data[30:0];
        CFG_FILTER_ALPHA:   filter_alpha   <= cfg_data[16:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      integral_acc <= '0;
      last_measure <= '0;
      last_deriv   <= '0;
      primed       <= 1'b0;
    end else begin
      if (result_valid && result_ready && state != ST_EMIT) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            err  <= item.error_in;
            meas <= item.measure_in;
            dt   <= item.step_time;
            if (item.kind == KIND_CLEAR) begin
              integral_acc <= '0;
              last_measure <= '0;
              last_deriv   <= '0;
              primed       <= 1'b0;
            end else if (!step_ok) begin
              fin_drive <= '0;
              fin_rej   <= 1'b1;
              state     <= ST_EMIT;
            end else begin
              if (!primed) begin
                last_measure <= item.measure_in;
                last_deriv   <= '0;
                primed       <= 1'b1;
              end
              state <= ST_MUL_GI;
            end
          end
        end
        ST_MUL_GI: begin
          quot_neg <= !diff[32] && diff != 33'sd0;
          state    <= ST_MUL_GP;
        end
        ST_MUL_GP: begin
          t1    <= qsat(prod);
          state <= ST_MUL_T1;
        end
        ST_MUL_T1: begin
          p_term <= qsat(prod);
          state  <= ST_ACC_I;
        end
        ST_ACC_I: begin
          integral_acc <= sat32(ext66(integral_acc) + ext66(qsat(prod)));
          state        <= ST_CLAMP_I;
        end
        ST_CLAMP_I: begin
          integral_acc <= clampsym(integral_acc, integral_bound);
          state        <= ST_SUM_P;
        end
        ST_SUM_P: begin
          out_acc <= sat32(ext66(p_term) + ext66(integral_acc));
          state   <= ST_WAIT_DIV;
        end
        ST_WAIT_DIV: begin
          if (!div_busy) begin
            raw   <= raw_sat;
            state <= ST_MUL_ALPHA;
          end
        end
        ST_MUL_ALPHA: begin
          state <= ST_DERIV;
        end
        ST_DERIV: begin
          last_deriv   <= sat32(ext66(last_deriv) + (prod >>> 16));
          last_measure <= meas;
          state        <= ST_MUL_GD;
        end
        ST_MUL_GD: begin
          state <= ST_SUM_D;
        end
        ST_SUM_D: begin
          out_acc <= sat32(ext66(out_acc) + ext66(qsat(prod)));
          state   <= ST_CLAMP_OUT;
        end
        ST_CLAMP_OUT: begin
          fin_drive <= clampsym(out_acc, drive_bound);
          fin_rej   <= 1'b0;
          state     <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            result.drive    <= fin_drive;
            result.rejected <= fin_rej;
            result_valid    <= 1'b1;
            state           <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // divider only runs inside an update
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !div_busy)
    else $error("divider busy while sequencer idle");

  a_rej_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.rejected |-> result.drive == 32'sd0)
    else $error("rejected result with nonzero drive");

  a_primed: assert property (@(posedge clk) disable iff (rst)
    accept && item.kind == KIND_UPDATE && step_ok |=> primed && state == ST_MUL_GI)
    else $error("valid update did not prime the controller");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    accept && item.kind == KIND_CLEAR |=> !primed && integral_acc == 32'sd0 && state == ST_IDLE)
    else $error("clear transaction did not reset state");

endmodule
